// ===== rtl/block_slot_allocator_top_assert.svh =====
// ---------------------------------------------------------------------------
// block_slot_allocator_top_assert.svh
// assertion macros used by the slot allocator core
// ---------------------------------------------------------------------------
`ifndef BLOCK_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define BLOCK_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BSA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot allocator check failed");

// next-cycle implication, checked outside reset
`define BSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot allocator check failed");

`endif

// ===== rtl/bsa_pkg.sv =====
// ---------------------------------------------------------------------------
// bsa_pkg
// shared types and constants of the block slot allocator
// ---------------------------------------------------------------------------
package bsa_pkg;

   // depth of the free stack and derived widths
   localparam int MAX_SLOTS = 1024;
   localparam int ADDR_W    = $clog2(MAX_SLOTS);
   localparam int CNT_W     = ADDR_W + 1;

   // fixed field widths
   localparam int SLOT_W    = 10;
   localparam int LIMIT_W   = 11;
   localparam int BYTES_W   = 21;
   localparam int OFFSET_W  = 30;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;

   // command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SLOT_LIMIT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_BYTES = 1'd1;

   // reset values of the registers
   localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RST  = 11'd1024;
   localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = 21'd4096;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_MUL,
      S_OUT
   } state_type;

   // free stack access from the core
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [SLOT_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   // finished result handed to the output register
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [OFFSET_W-1:0] offset;
   } result_type;

endpackage

// ===== rtl/block_slot_allocator_top.sv =====
// ---------------------------------------------------------------------------
// block_slot_allocator_top
// lifo free-list slot allocator with bump pointer fallback
// ---------------------------------------------------------------------------
//  channel   ports                                  direction
//  req       req_valid/req_stall, command, slot     in
//  rsp       rsp_valid/rsp_stall, status/slot/off   out
//  csr       csr_we, csr_index, csr_wdata           in, write only
//
//  a transaction steps through idle, mul and out (free, fresh grant, full)
//  or idle, read, mul and out (pop from the stack), set by the registered
//  stack ram read and offset multiplier; one transaction is in flight at a time
//  synchronous reset clears the stack pointer and bump counter; the stack
//  ram itself needs no clearing
//  the output register holds a result while rsp_stall is high; the next
//  request is taken while that result waits
// ---------------------------------------------------------------------------
module block_slot_allocator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [bsa_pkg::SLOT_W-1:0]        req_freed_slot,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bsa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bsa_pkg::SLOT_W-1:0]        rsp_granted_slot,
   output logic [bsa_pkg::OFFSET_W-1:0]      rsp_byte_offset,
   input  logic                              csr_we,
   input  logic [bsa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bsa_pkg::BYTES_W-1:0]       csr_wdata
);

   bsa_pkg::mem_req_type         mem_req;
   logic [bsa_pkg::SLOT_W-1:0]   mem_rdata;
   logic                         res_valid;
   logic                         res_load;
   bsa_pkg::result_type          res;
   logic                         rsp_valid_ff;
   bsa_pkg::result_type          rsp_ff;

   // output register may load when empty or being drained
   assign res_load = !rsp_valid_ff || !rsp_stall;

   bsa_core u_core (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_freed_slot (req_freed_slot),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mem_req        (mem_req),
      .mem_rdata      (mem_rdata),
      .res_valid      (res_valid),
      .res_load       (res_load),
      .res            (res)
   );

   // free stack storage
   bsa_ram #(
      .WIDTH (bsa_pkg::SLOT_W),
      .DEPTH (bsa_pkg::MAX_SLOTS)
   ) u_stack_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .re    (mem_req.re),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= res_valid;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (res_load && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_granted_slot = rsp_ff.slot;
   assign rsp_byte_offset  = rsp_ff.offset;

endmodule

// ===== rtl/bsa_ram.sv =====
// ---------------------------------------------------------------------------
// bsa_ram
// generic simple dual-port ram with registered read
// ---------------------------------------------------------------------------
module bsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bsa_core.sv =====
// ---------------------------------------------------------------------------
// bsa_core
// command sequencer: stack pointer, bump counter, registers and offset
// ---------------------------------------------------------------------------
`include "block_slot_allocator_top_assert.svh"

module bsa_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command,
   input  logic [bsa_pkg::SLOT_W-1:0]       req_freed_slot,
   input  logic                             csr_we,
   input  logic [bsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bsa_pkg::BYTES_W-1:0]      csr_wdata,
   output bsa_pkg::mem_req_type             mem_req,
   input  logic [bsa_pkg::SLOT_W-1:0]       mem_rdata,
   output logic                             res_valid,
   input  logic                             res_load,
   output bsa_pkg::result_type              res
);

   bsa_pkg::state_type                state_ff, state_in;
   logic [bsa_pkg::CNT_W-1:0]         stack_count_ff, stack_count_in;
   logic [bsa_pkg::CNT_W-1:0]         next_fresh_ff, next_fresh_in;
   logic [bsa_pkg::LIMIT_W-1:0]       slot_limit_ff;
   logic [bsa_pkg::BYTES_W-1:0]       block_bytes_ff;
   logic [bsa_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic [bsa_pkg::SLOT_W-1:0]        slot_ff, slot_in;
   logic                              granted_ff, granted_in;
   logic [bsa_pkg::OFFSET_W-1:0]      offset_ff, offset_in;
   logic                              accept;
   logic [31:0]                       limit_eff;
   logic                              stack_full;
   logic                              stack_empty;
   logic                              fresh_full;
   logic [bsa_pkg::SLOT_W+bsa_pkg::BYTES_W-1:0] product;

   assign accept = req_valid && !req_stall;

   // effective limit is the smaller of the register and the stack depth
   always_comb begin
      if (32'(slot_limit_ff) > 32'(bsa_pkg::MAX_SLOTS)) begin
         limit_eff = 32'(bsa_pkg::MAX_SLOTS);
      end else begin
         limit_eff = 32'(slot_limit_ff);
      end
   end

   assign stack_full  = 32'(stack_count_ff) >= 32'(bsa_pkg::MAX_SLOTS);
   assign stack_empty = stack_count_ff == '0;
   assign fresh_full  = 32'(next_fresh_ff) >= limit_eff;

   // offset multiplier
   assign product = (bsa_pkg::SLOT_W+bsa_pkg::BYTES_W)'(slot_ff)
                  * (bsa_pkg::SLOT_W+bsa_pkg::BYTES_W)'(block_bytes_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_limit_ff  <= bsa_pkg::SLOT_LIMIT_RST;
         block_bytes_ff <= bsa_pkg::BLOCK_BYTES_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            bsa_pkg::REG_SLOT_LIMIT:  slot_limit_ff  <= csr_wdata[bsa_pkg::LIMIT_W-1:0];
            bsa_pkg::REG_BLOCK_BYTES: block_bytes_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bsa_pkg::S_IDLE;
         stack_count_ff <= '0;
         next_fresh_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         stack_count_ff <= stack_count_in;
         next_fresh_ff  <= next_fresh_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      slot_ff    <= slot_in;
      granted_ff <= granted_in;
      offset_ff  <= offset_in;
   end

   // next state, stack access and result build-up
   always_comb begin
      state_in       = state_ff;
      stack_count_in = stack_count_ff;
      next_fresh_in  = next_fresh_ff;
      status_in      = status_ff;
      slot_in        = slot_ff;
      granted_in     = granted_ff;
      offset_in      = offset_ff;
      mem_req        = '0;
      req_stall      = 1'b1;
      res_valid      = 1'b0;

      unique case (state_ff)
         bsa_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               status_in  = bsa_pkg::ST_OK;
               slot_in    = '0;
               granted_in = 1'b0;
               state_in   = bsa_pkg::S_MUL;
               if (req_command == bsa_pkg::CMD_FREE) begin
                  // push onto the stack unless it is full
                  if (stack_full) begin
                     status_in = bsa_pkg::ST_OVERFLOW;
                  end else begin
                     mem_req.we     = 1'b1;
                     mem_req.waddr  = stack_count_ff[bsa_pkg::ADDR_W-1:0];
                     mem_req.wdata  = req_freed_slot;
                     stack_count_in = stack_count_ff + 1'b1;
                  end
               end else if (!stack_empty) begin
                  // pop the top entry, data returns next cycle
                  mem_req.re     = 1'b1;
                  mem_req.raddr  = bsa_pkg::ADDR_W'(stack_count_ff - 1'b1);
                  stack_count_in = stack_count_ff - 1'b1;
                  granted_in     = 1'b1;
                  state_in       = bsa_pkg::S_READ;
               end else if (fresh_full) begin
                  status_in = bsa_pkg::ST_FULL;
               end else begin
                  // hand out a never-used slot
                  slot_in       = bsa_pkg::SLOT_W'(next_fresh_ff);
                  granted_in    = 1'b1;
                  next_fresh_in = next_fresh_ff + 1'b1;
               end
            end
         end
         bsa_pkg::S_READ: begin
            slot_in  = mem_rdata;
            state_in = bsa_pkg::S_MUL;
         end
         bsa_pkg::S_MUL: begin
            offset_in = granted_ff ? product[bsa_pkg::OFFSET_W-1:0] : '0;
            state_in  = bsa_pkg::S_OUT;
         end
         bsa_pkg::S_OUT: begin
            res_valid = 1'b1;
            if (res_load) begin
               state_in = bsa_pkg::S_IDLE;
            end
         end
         default: state_in = bsa_pkg::S_IDLE;
      endcase
   end

   assign res.status = status_ff;
   assign res.slot   = slot_ff;
   assign res.offset = offset_ff;

   // checks
   `BSA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, 32'(stack_count_ff) <= 32'(bsa_pkg::MAX_SLOTS))
   `BSA_ASSERT_NEXT(a_read_then_mul, clock, reset, state_ff == bsa_pkg::S_READ, state_ff == bsa_pkg::S_MUL)
   `BSA_ASSERT_NOW(a_no_wr_rd, clock, reset, mem_req.we, !mem_req.re)
   `BSA_ASSERT_NEXT(a_pop_count, clock, reset, mem_req.re, stack_count_ff == $past(stack_count_ff) - 1'b1)

endmodule

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the lifo free-list slot allocator: a directed table
// walks the corner cases, then random command bursts run under changing
// register settings and idling patterns
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLS = 8;
   localparam int TAIL_CYCLS   = 12;
   localparam int SEG_ITEMS    = 72;

   // short names for the directed table
   localparam logic                             ALLOC = bsa_pkg::CMD_ALLOC;
   localparam logic                             FREE  = bsa_pkg::CMD_FREE;
   localparam logic [bsa_pkg::CSR_IDX_W-1:0]    R_LIM = bsa_pkg::REG_SLOT_LIMIT;
   localparam logic [bsa_pkg::CSR_IDX_W-1:0]    R_BYT = bsa_pkg::REG_BLOCK_BYTES;
   localparam logic [bsa_pkg::STATUS_W-1:0]     OK    = bsa_pkg::ST_OK;
   localparam logic [bsa_pkg::STATUS_W-1:0]     FULL  = bsa_pkg::ST_FULL;

   typedef enum logic {ROW_TXN, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                      kind;
      logic                              cmd;
      logic [bsa_pkg::SLOT_W-1:0]        slot;
      logic [bsa_pkg::CSR_IDX_W-1:0]     idx;
      logic [bsa_pkg::BYTES_W-1:0]       wdata;
      bit                                typed;
      logic [bsa_pkg::STATUS_W-1:0]      want_status;
      logic [bsa_pkg::SLOT_W-1:0]        want_slot;
      logic [bsa_pkg::OFFSET_W-1:0]      want_offset;
   } row_type;

   // dut ports
   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic                              req_command = bsa_pkg::CMD_ALLOC;
   logic [bsa_pkg::SLOT_W-1:0]        req_freed_slot = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [bsa_pkg::STATUS_W-1:0]      rsp_status;
   logic [bsa_pkg::SLOT_W-1:0]        rsp_granted_slot;
   logic [bsa_pkg::OFFSET_W-1:0]      rsp_byte_offset;
   logic                              csr_we = 1'b0;
   logic [bsa_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [bsa_pkg::BYTES_W-1:0]       csr_wdata = '0;

   // allocator shadow state and register copies
   logic [bsa_pkg::SLOT_W-1:0]  stack_mem [bsa_pkg::MAX_SLOTS];
   int                          stack_depth = 0;
   int                          fresh_ptr = 0;
   logic [bsa_pkg::LIMIT_W-1:0] cfg_limit = bsa_pkg::SLOT_LIMIT_RST;
   logic [bsa_pkg::BYTES_W-1:0] cfg_bytes = bsa_pkg::BLOCK_BYTES_RST;

   bsa_pkg::result_type pending_grants [$];
   bsa_pkg::result_type got_rsp;
   bsa_pkg::result_type want_rsp;
   int                  errors = 0;
   int                  cycle_count = 0;
   int                  idle_pct = 0;
   int                  stall_pct = 0;

   // directed corner cases, typed results only where obvious
   row_type dir_table [32] = '{
      '{ROW_TXN, ALLOC, 10'd0,    R_LIM, 21'd0, 1, OK,   10'd0,    30'd0},
      '{ROW_TXN, ALLOC, 10'd0,    R_LIM, 21'd0, 1, OK,   10'd1,    30'd4096},
      '{ROW_TXN, FREE,  10'd1023, R_LIM, 21'd0, 1, OK,   10'd0,    30'd0},
      '{ROW_TXN, ALLOC, 10'd0,    R_LIM, 21'd0, 1, OK,   10'd1023, 30'd4190208},
      '{ROW_TXN, FREE,  10'd0,    R_LIM, 21'd0, 1, OK,   10'd0,    30'd0},
      '{ROW_TXN, FREE,  10'd1023, R_LIM, 21'd0, 1, OK,   10'd0,    30'd0},
      '{ROW_TXN, ALLOC, 10'd0,    R_LIM, 21'd0, 0, OK,   10'd0,    30'd0},
      '{ROW_TXN, ALLOC, 10'd0,    R_LIM, 21'd0, 0, OK,   10'd0,    30'd0},
      '{ROW_TXN, FREE,  10'd5,    R_LIM, 21'd0, 0, OK,   10'd0,    30'd0},
      '{ROW_TXN, FREE,  10'd5,    R_LIM, 21'd0, 0, OK,   10'd0,    30'd0},
      '{ROW_TXN, ALLOC, 10'd0,    R_LIM, 21'd0, 0, OK,   10'd0,    30'd0},
      '{ROW_TXN, ALLOC, 10'd0,    R_LIM, 21'd0, 0, OK,   10'd0,    30'd0},
      '{ROW_CSR, ALLOC, 10'd0,    R_LIM, 21'd0, 0, OK,   10'd0,    30'd0},
      '{ROW_TXN, ALLOC, 10'd0,    R_LIM, 21'd0, 1, FULL, 10'd0,    30'd0},
      '{ROW_TXN, FREE,  10'd700,  R_LIM, 21'd0, 0, OK,   10'd0,    30'd0},
      '{ROW_TXN, ALLOC, 10'd0,    R_LIM, 21'd0, 0, OK,   10'd0,    30'd0},
      '{ROW_TXN, ALLOC, 10'd0,    R_LIM, 21'd0, 1, FULL, 10'd0,    30'd0},
      '{ROW_CSR, ALLOC, 10'd0,    R_BYT, 21'd1, 0, OK,   10'd0,    30'd0},
      '{ROW_TXN, FREE,  10'd1023, R_LIM, 21'd0, 0, OK,   10'd0,    30'd0},
      '{ROW_TXN, ALLOC, 10'd0,    R_LIM, 21'd0, 1, OK,   10'd1023, 30'd1023},
      '{ROW_CSR, ALLOC, 10'd0,    R_BYT, 21'd1048576, 0, OK, 10'd0, 30'd0},
      '{ROW_TXN, FREE,  10'd1023, R_LIM, 21'd0, 0, OK,   10'd0,    30'd0},
      '{ROW_TXN, ALLOC, 10'd0,    R_LIM, 21'd0, 1, OK,   10'd1023, 30'd1072693248},
      '{ROW_CSR, ALLOC, 10'd0,    R_BYT, 21'd2097151, 0, OK, 10'd0, 30'd0},
      '{ROW_TXN, FREE,  10'd1023, R_LIM, 21'd0, 0, OK,   10'd0,    30'd0},
      '{ROW_TXN, ALLOC, 10'd0,    R_LIM, 21'd0, 0, OK,   10'd0,    30'd0},
      '{ROW_CSR, ALLOC, 10'd0,    R_LIM, 21'd2047, 0, OK, 10'd0,   30'd0},
      '{ROW_TXN, ALLOC, 10'd0,    R_LIM, 21'd0, 0, OK,   10'd0,    30'd0},
      '{ROW_CSR, ALLOC, 10'd0,    R_BYT, 21'd0, 0, OK,   10'd0,    30'd0},
      '{ROW_TXN, ALLOC, 10'd0,    R_LIM, 21'd0, 0, OK,   10'd0,    30'd0},
      '{ROW_CSR, ALLOC, 10'd0,    R_LIM, 21'd1024, 0, OK, 10'd0,   30'd0},
      '{ROW_CSR, ALLOC, 10'd0,    R_BYT, 21'd4096, 0, OK, 10'd0,   30'd0}
   };

   block_slot_allocator_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_freed_slot   (req_freed_slot),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_byte_offset  (rsp_byte_offset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // compare each accepted response with the oldest pending grant
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_rsp = '{rsp_status, rsp_granted_slot, rsp_byte_offset};
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected response status %0d slot %0d offset %0d",
                     $time, rsp_status, rsp_granted_slot, rsp_byte_offset);
            errors++;
         end else begin
            want_rsp = pending_grants.pop_front();
            if (got_rsp.status !== want_rsp.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want_rsp.status, got_rsp.status);
               errors++;
            end
            if (got_rsp.slot !== want_rsp.slot) begin
               $display("%0t: granted_slot expected %0d actual %0d",
                        $time, want_rsp.slot, got_rsp.slot);
               errors++;
            end
            if (got_rsp.offset !== want_rsp.offset) begin
               $display("%0t: byte_offset expected %0d actual %0d",
                        $time, want_rsp.offset, got_rsp.offset);
               errors++;
            end
         end
      end
   end

   // next allocator result, updating the shadow stack and bump counter
   function automatic bsa_pkg::result_type compute_grant(
         input logic cmd, input logic [bsa_pkg::SLOT_W-1:0] slot);
      bsa_pkg::result_type r;
      int                  eff_limit;
      logic [50:0]         prod;
      r = '0;
      if (cmd == bsa_pkg::CMD_FREE) begin
         if (stack_depth >= bsa_pkg::MAX_SLOTS) begin
            r.status = bsa_pkg::ST_OVERFLOW;
         end else begin
            stack_mem[stack_depth] = slot;
            stack_depth++;
         end
      end else if (stack_depth > 0) begin
         stack_depth--;
         r.slot = stack_mem[stack_depth];
      end else begin
         eff_limit = (cfg_limit > bsa_pkg::MAX_SLOTS) ? bsa_pkg::MAX_SLOTS
                                                      : int'(cfg_limit);
         if (fresh_ptr >= eff_limit) begin
            r.status = bsa_pkg::ST_FULL;
         end else begin
            r.slot = fresh_ptr[bsa_pkg::SLOT_W-1:0];
            fresh_ptr++;
         end
      end
      if (cmd == bsa_pkg::CMD_ALLOC && r.status == bsa_pkg::ST_OK) begin
         prod = r.slot * cfg_bytes;
         r.offset = prod[bsa_pkg::OFFSET_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [bsa_pkg::SLOT_W-1:0] pick_slot();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return bsa_pkg::SLOT_W'($urandom_range(bsa_pkg::MAX_SLOTS - 1));
      endcase
   endfunction

   task automatic set_idling(input int mode);
      case (mode)
         0:       begin idle_pct = 0;  stall_pct = 0;  end
         1:       begin idle_pct = 46; stall_pct = 0;  end
         2:       begin idle_pct = 0;  stall_pct = 46; end
         default: begin idle_pct = 24; stall_pct = 24; end
      endcase
   endtask

   task automatic wait_drained();
      while (pending_grants.size() != 0) @(posedge clock);
   endtask

   // present one transaction, hold it until taken, then record the grant
   task automatic issue_command(input logic cmd, input logic [bsa_pkg::SLOT_W-1:0] slot,
                                input bit use_typed,
                                input bsa_pkg::result_type typed_want);
      bsa_pkg::result_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_freed_slot <= slot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = compute_grant(cmd, slot);
      pending_grants = {pending_grants, (use_typed ? typed_want : predicted)};
   endtask

   // register write once the allocator has gone quiet
   task automatic write_register(input logic [bsa_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [bsa_pkg::BYTES_W-1:0] data);
      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLS) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == bsa_pkg::REG_SLOT_LIMIT) cfg_limit = data[bsa_pkg::LIMIT_W-1:0];
      else if (idx == bsa_pkg::REG_BLOCK_BYTES) cfg_bytes = data;
   endtask

   initial begin
      bsa_pkg::result_type         typed_want;
      logic [bsa_pkg::BYTES_W-1:0] val;
      int                          n;
      int                          burst;
      int                          burst_kind;
      logic                        cmd;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      set_idling(0);
      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_CSR) begin
            write_register(dir_table[i].idx, dir_table[i].wdata);
         end else begin
            typed_want = '{dir_table[i].want_status, dir_table[i].want_slot,
                           dir_table[i].want_offset};
            issue_command(dir_table[i].cmd, dir_table[i].slot, dir_table[i].typed,
                          typed_want);
         end
      end

      // random bursts under changing settings and idling
      for (int seg = 0; seg < 8; seg++) begin
         set_idling(seg % 4);
         case ($urandom_range(7))
            0:       val = 0;
            1:       val = 1;
            2:       val = bsa_pkg::BYTES_W'(fresh_ptr);
            3:       val = bsa_pkg::BYTES_W'(fresh_ptr + 1);
            4:       val = bsa_pkg::BYTES_W'(bsa_pkg::MAX_SLOTS);
            5:       val = 2047;
            6:       val = bsa_pkg::BYTES_W'($urandom_range(bsa_pkg::MAX_SLOTS));
            default: val = bsa_pkg::BYTES_W'($urandom);
         endcase
         write_register(bsa_pkg::REG_SLOT_LIMIT, val);
         case ($urandom_range(7))
            0:       val = 1;
            1:       val = 4096;
            2:       val = 1048576;
            3:       val = '1;
            4:       val = 0;
            7:       val = bsa_pkg::BYTES_W'($urandom);
            default: val = bsa_pkg::BYTES_W'($urandom_range(1, 1048576));
         endcase
         write_register(bsa_pkg::REG_BLOCK_BYTES, val);
         n = 0;
         while (n < SEG_ITEMS) begin
            burst      = $urandom_range(1, 12);
            burst_kind = $urandom_range(2);
            for (int j = 0; j < burst; j++) begin
               if (burst_kind == 0) cmd = bsa_pkg::CMD_FREE;
               else if (burst_kind == 1) cmd = bsa_pkg::CMD_ALLOC;
               else cmd = 1'($urandom_range(1));
               issue_command(cmd, pick_slot(), 0, '0);
               n++;
            end
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLS) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
